>>> sv/leqt_pkg.sv
package leqt_pkg;

  // request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_MERGE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;

  // port widths fixed by the word format
  localparam int unsigned LABEL_W = 10;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MRA,
    S_MRB,
    S_WALK,
    S_TK,
    S_TX
  } state_t;

endpackage

>>> sv/leqt_ram.sv
module leqt_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/label_equivalence_table.sv
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+----------------------------
// request   | in_req_type, in_label_a, in_label_b        | taken when start && !busy
// result    | out_label_out, out_status                  | out_valid, one cycle, no hold
//
// Steps: allocate, full, bad operand or unused code answer from S_IDLE; lookup goes through S_LOOK.
// Merge goes through S_MRA, S_MRB, S_WALK, S_TK and S_TX (equal roots: ends after S_MRB).
// The merge walk reads one next_link per cycle, over each member of the absorbed set.
// Reset: rst_n synchronous, active low; clears the label count and control only.
// The table memories are not cleared; only labels below the count are ever read.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module label_equivalence_table #(
  parameter int unsigned MAX_LABELS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [leqt_pkg::REQ_W-1:0]    in_req_type,
  input  logic [leqt_pkg::LABEL_W-1:0]  in_label_a,
  input  logic [leqt_pkg::LABEL_W-1:0]  in_label_b,
  output logic                          out_valid,
  output logic [leqt_pkg::LABEL_W-1:0]  out_label_out,
  output logic [leqt_pkg::STAT_W-1:0]   out_status
);

  localparam int unsigned LW   = $clog2(MAX_LABELS);      // label index width
  localparam int unsigned CW   = $clog2(MAX_LABELS + 1);  // label count width
  localparam int unsigned NW   = LW + 1;                  // next link, room for null
  localparam int unsigned CMPW = (CW > leqt_pkg::LABEL_W) ? CW : leqt_pkg::LABEL_W;
  localparam logic [NW-1:0] NO_LINK = NW'(MAX_LABELS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LABELS);
  localparam logic [leqt_pkg::LABEL_W-1:0] FULL_LABEL = leqt_pkg::LABEL_W'(MAX_LABELS - 1);

  leqt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;            // labels in use
  logic [LW-1:0] b_r, b_nxt;                // second merge operand
  logic [LW-1:0] u_r, u_nxt;                // root of operand a
  logic [LW-1:0] keep_r, keep_nxt;          // surviving root
  logic [LW-1:0] absorb_r, absorb_nxt;      // root being relinked
  logic [LW-1:0] kt_r, kt_nxt;              // tail of the surviving list

  logic                          out_valid_r, out_valid_nxt;
  logic [leqt_pkg::LABEL_W-1:0]  out_label_r, out_label_nxt;
  logic [leqt_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;

  // memory ports
  logic          rep_we, nl_we, tl_we;
  logic [LW-1:0] rep_waddr, rep_raddr, rep_wdata, rep_q;
  logic [LW-1:0] nl_waddr, nl_raddr;
  logic [NW-1:0] nl_wdata, nl_q;
  logic [LW-1:0] tl_waddr, tl_raddr, tl_wdata, tl_q;

  logic [LW-1:0] a_idx, b_idx, nl_idx;
  logic          a_ok, b_ok, link_ok;

  assign a_idx   = LW'(in_label_a);
  assign b_idx   = LW'(in_label_b);
  assign a_ok    = CMPW'(in_label_a) < CMPW'(cnt_r);
  assign b_ok    = CMPW'(in_label_b) < CMPW'(cnt_r);
  assign nl_idx  = LW'(nl_q);
  assign link_ok = nl_q < NO_LINK;

  leqt_ram #(.WIDTH(LW), .DEPTH(MAX_LABELS)) u_rep (
    .clk  (clk),
    .we   (rep_we),
    .waddr(rep_waddr),
    .wdata(rep_wdata),
    .raddr(rep_raddr),
    .rdata(rep_q)
  );

  leqt_ram #(.WIDTH(NW), .DEPTH(MAX_LABELS)) u_next (
    .clk  (clk),
    .we   (nl_we),
    .waddr(nl_waddr),
    .wdata(nl_wdata),
    .raddr(nl_raddr),
    .rdata(nl_q)
  );

  leqt_ram #(.WIDTH(LW), .DEPTH(MAX_LABELS)) u_tail (
    .clk  (clk),
    .we   (tl_we),
    .waddr(tl_waddr),
    .wdata(tl_wdata),
    .raddr(tl_raddr),
    .rdata(tl_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= leqt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    b_r          <= b_nxt;
    u_r          <= u_nxt;
    keep_r       <= keep_nxt;
    absorb_r     <= absorb_nxt;
    kt_r         <= kt_nxt;
    out_label_r  <= out_label_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    b_nxt          = b_r;
    u_nxt          = u_r;
    keep_nxt       = keep_r;
    absorb_nxt     = absorb_r;
    kt_nxt         = kt_r;
    out_valid_nxt  = 1'b0;
    out_label_nxt  = out_label_r;
    out_status_nxt = out_status_r;

    rep_we    = 1'b0;
    rep_waddr = keep_r;
    rep_wdata = keep_r;
    rep_raddr = a_idx;
    nl_we     = 1'b0;
    nl_waddr  = kt_r;
    nl_wdata  = {1'b0, absorb_r};
    nl_raddr  = nl_idx;
    tl_we     = 1'b0;
    tl_waddr  = keep_r;
    tl_wdata  = tl_q;
    tl_raddr  = keep_r;

    case (state_r)
      leqt_pkg::S_IDLE: begin
        if (start) begin
          b_nxt = b_idx;
          case (in_req_type)
            leqt_pkg::REQ_ALLOC: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CNT_MAX) begin
                out_label_nxt  = FULL_LABEL;
                out_status_nxt = leqt_pkg::STAT_FULL;
              end else begin
                // new label is its own one-member set
                rep_we    = 1'b1;
                rep_waddr = LW'(cnt_r);
                rep_wdata = LW'(cnt_r);
                nl_we     = 1'b1;
                nl_waddr  = LW'(cnt_r);
                nl_wdata  = NO_LINK;
                tl_we     = 1'b1;
                tl_waddr  = LW'(cnt_r);
                tl_wdata  = LW'(cnt_r);
                cnt_nxt   = cnt_r + 1'b1;
                out_label_nxt  = leqt_pkg::LABEL_W'(cnt_r);
                out_status_nxt = leqt_pkg::STAT_OK;
              end
            end
            leqt_pkg::REQ_MERGE: begin
              if (a_ok && b_ok) begin
                state_nxt = leqt_pkg::S_MRA;
              end else begin
                out_valid_nxt  = 1'b1;
                out_label_nxt  = '0;
                out_status_nxt = leqt_pkg::STAT_NOT_ALLOC;
              end
            end
            leqt_pkg::REQ_LOOKUP: begin
              if (a_ok) begin
                state_nxt = leqt_pkg::S_LOOK;
              end else begin
                out_valid_nxt  = 1'b1;
                out_label_nxt  = '0;
                out_status_nxt = leqt_pkg::STAT_NOT_ALLOC;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_label_nxt  = '0;
              out_status_nxt = leqt_pkg::STAT_OK;
            end
          endcase
        end
      end
      leqt_pkg::S_LOOK: begin
        out_valid_nxt  = 1'b1;
        out_label_nxt  = leqt_pkg::LABEL_W'(rep_q);
        out_status_nxt = leqt_pkg::STAT_OK;
        state_nxt      = leqt_pkg::S_IDLE;
      end
      leqt_pkg::S_MRA: begin
        u_nxt     = rep_q;
        rep_raddr = b_r;
        state_nxt = leqt_pkg::S_MRB;
      end
      leqt_pkg::S_MRB: begin
        if (u_r == rep_q) begin
          out_valid_nxt  = 1'b1;
          out_label_nxt  = leqt_pkg::LABEL_W'(u_r);
          out_status_nxt = leqt_pkg::STAT_OK;
          state_nxt      = leqt_pkg::S_IDLE;
        end else begin
          // larger root is absorbed; relabel its head and fetch its link
          keep_nxt   = (u_r < rep_q) ? u_r : rep_q;
          absorb_nxt = (u_r < rep_q) ? rep_q : u_r;
          rep_we     = 1'b1;
          rep_waddr  = absorb_nxt;
          rep_wdata  = keep_nxt;
          nl_raddr   = absorb_nxt;
          state_nxt  = leqt_pkg::S_WALK;
        end
      end
      leqt_pkg::S_WALK: begin
        if (link_ok) begin
          rep_we    = 1'b1;
          rep_waddr = nl_idx;
          rep_wdata = keep_r;
          nl_raddr  = nl_idx;
        end else begin
          tl_raddr  = keep_r;
          state_nxt = leqt_pkg::S_TK;
        end
      end
      leqt_pkg::S_TK: begin
        kt_nxt    = tl_q;
        tl_raddr  = absorb_r;
        state_nxt = leqt_pkg::S_TX;
      end
      leqt_pkg::S_TX: begin
        // splice absorbed list after the keeper's tail
        nl_we          = 1'b1;
        nl_waddr       = kt_r;
        nl_wdata       = {1'b0, absorb_r};
        tl_we          = 1'b1;
        tl_waddr       = keep_r;
        tl_wdata       = tl_q;
        out_valid_nxt  = 1'b1;
        out_label_nxt  = leqt_pkg::LABEL_W'(keep_r);
        out_status_nxt = leqt_pkg::STAT_OK;
        state_nxt      = leqt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = leqt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != leqt_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_label_out = out_label_r;
  assign out_status    = out_status_r;

  // a result word follows either an accepted request or a busy cycle
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a request");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("label count above table size");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == leqt_pkg::STAT_FULL) |-> ($past(cnt_r) == CNT_MAX)
      && $stable(cnt_r))
    else $error("full reported with free labels");

  a_splice_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == leqt_pkg::S_TX) |=> (out_valid && !busy))
    else $error("merge finished without result");

endmodule
